/* design/tns_pkg.sv */
`timescale 1ns / 1ps

package tns_pkg;

  localparam int COORD_W  = 24;
  localparam int IDX_W    = 16;
  localparam int CH_W     = 8;
  localparam int TEXEL_W  = 3 * CH_W;
  localparam int SIZE_W   = 9;
  localparam int CFG_IDX_W = 8;
  // Largest linear texel offset is 510 * 511 + 510, which fits in 18 bits.
  localparam int LIN_W    = 2 * SIZE_W;

  localparam int STORE_DEPTH_DEF   = 65536;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [SIZE_W-1:0] TEX_SIZE_RST = SIZE_W'(256);

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic {
    WRAP_REPEAT = 1'b0,
    WRAP_CLAMP  = 1'b1
  } wrap_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WRAP_MODE  = 8'd0,
    CFG_TEX_WIDTH  = 8'd1,
    CFG_TEX_HEIGHT = 8'd2
  } cfg_reg_e;

  typedef struct packed {
    cmd_e                       cmd;
    logic signed [COORD_W-1:0]  coord_u;
    logic signed [COORD_W-1:0]  coord_v;
    logic [IDX_W-1:0]           texel_index;
    logic [CH_W-1:0]            red_in;
    logic [CH_W-1:0]            green_in;
    logic [CH_W-1:0]            blue_in;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic [CH_W-1:0] texel_x;
    logic [CH_W-1:0] texel_y;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [SIZE_W-1:0]    wdata;
  } cfg_write_t;

  typedef struct packed {
    wrap_mode_e        wrap_mode;
    logic [SIZE_W-1:0] tex_width;
    logic [SIZE_W-1:0] tex_height;
  } tns_cfg_t;

  // Memory request leaving the address pipeline.
  typedef struct packed {
    logic               valid;
    logic               sample;
    logic               write_ok;
    logic [SIZE_W-1:0]  x;
    logic [SIZE_W-1:0]  y;
    logic [TEXEL_W-1:0] wdata;
  } tns_req_t;

endpackage

/* design/tns_stream_if.sv */
`timescale 1ns / 1ps

interface tns_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

/* design/tns_ram.sv */
`timescale 1ns / 1ps

module tns_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/tns_addr_gen.sv */
`timescale 1ns / 1ps

module tns_addr_gen #(
  parameter int STORE_DEPTH   = tns_pkg::STORE_DEPTH_DEF,
  parameter int FRACTION_BITS = tns_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  logic                           accept_i,
  input  tns_pkg::in_item_t              item_i,
  input  tns_pkg::tns_cfg_t              cfg_i,
  output tns_pkg::tns_req_t              req_o,
  output logic [$clog2(STORE_DEPTH)-1:0] addr_o
);

  import tns_pkg::*;

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int DW    = $clog2(STORE_DEPTH + 1);
  localparam int RW    = ((LIN_W > DW) ? LIN_W : DW) + 1;
  localparam int RECIP = (1 << LIN_W) / STORE_DEPTH;
  localparam int EW    = COORD_W + 2;

  localparam logic [LIN_W-1:0] RECIP_C = LIN_W'(RECIP);
  localparam logic [DW-1:0]    DEPTH_C = DW'(STORE_DEPTH);
  localparam logic [RW-1:0]    DEPTH_R = RW'(STORE_DEPTH);
  localparam logic signed [EW-1:0] ONE_S =
    {{(EW - 1 - FRACTION_BITS){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [FRACTION_BITS:0] ONE_F = {1'b1, {FRACTION_BITS{1'b0}}};

  typedef struct packed {
    logic               sample;
    logic               write_ok;
    logic [SIZE_W-1:0]  x;
    logic [SIZE_W-1:0]  y;
    logic [IDX_W-1:0]   idx;
    logic [TEXEL_W-1:0] rgb;
  } tag_t;

  // Repeat keeps the fraction, except that a whole value above one maps to one.
  function automatic logic [FRACTION_BITS:0] fold(input logic [COORD_W-1:0] c,
                                                  input logic clamp);
    logic signed [EW-1:0]     ce;
    logic [FRACTION_BITS-1:0] frac;
    logic [FRACTION_BITS:0]   f;
    ce   = {{2{c[COORD_W-1]}}, c};
    frac = c[FRACTION_BITS-1:0];
    priority if (ce > ONE_S) begin
      f = (clamp || frac == '0) ? ONE_F : {1'b0, frac};
    end else if (ce[EW-1]) begin
      f = clamp ? '0 : {1'b0, frac};
    end else begin
      f = ce[FRACTION_BITS:0];
    end
    return f;
  endfunction

  logic [5:0] vld_q;

  logic [FRACTION_BITS:0] fu_q, fv_q;
  tag_t                   tag1_q, tag2_q, tag3_q, tag4_q, tag5_q, tag6_q;
  logic [LIN_W-1:0]       lin3_q, lin4_q;
  logic [LIN_W-1:0]       q4_q;
  logic [RW-1:0]          r5_q;
  logic [AW-1:0]          addr6_q;

  logic [SIZE_W-1:0]              span_x, span_y, w_eff;
  logic [FRACTION_BITS+SIZE_W:0]  px, py;
  logic [LIN_W-1:0]               lin_d;
  logic [2*LIN_W-1:0]             pq;
  logic [LIN_W+DW-1:0]            pd;
  logic [RW-1:0]                  r_d;
  logic [RW-1:0]                  r_fix;
  tag_t                           tag1_d;
  tag_t                           tag2_d;

  always_comb begin
    span_x = (cfg_i.tex_width == '0) ? '0 : cfg_i.tex_width - SIZE_W'(1);
    span_y = (cfg_i.tex_height == '0) ? '0 : cfg_i.tex_height - SIZE_W'(1);
    w_eff  = (cfg_i.tex_width == '0) ? SIZE_W'(1) : cfg_i.tex_width;

    tag1_d.sample   = (item_i.cmd == CMD_SAMPLE);
    tag1_d.write_ok = (32'(item_i.texel_index) < 32'(STORE_DEPTH));
    tag1_d.x        = '0;
    tag1_d.y        = '0;
    tag1_d.idx      = item_i.texel_index;
    tag1_d.rgb      = {item_i.red_in, item_i.green_in, item_i.blue_in};

    px       = fu_q * span_x;
    py       = fv_q * span_y;
    tag2_d   = tag1_q;
    tag2_d.x = px[FRACTION_BITS+SIZE_W-1:FRACTION_BITS];
    tag2_d.y = py[FRACTION_BITS+SIZE_W-1:FRACTION_BITS];

    lin_d = LIN_W'(tag2_q.y) * LIN_W'(w_eff) + LIN_W'(tag2_q.x);
    pq    = lin3_q * RECIP_C;
    pd    = q4_q * DEPTH_C;
    // The reciprocal estimate is at most one low, so one correction remains.
    r_d   = RW'(lin4_q) - RW'(pd);
    r_fix = (r5_q >= DEPTH_R) ? r5_q - DEPTH_R : r5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[4:0], accept_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fu_q      <= fold(item_i.coord_u, cfg_i.wrap_mode == WRAP_CLAMP);
      fv_q      <= fold(item_i.coord_v, cfg_i.wrap_mode == WRAP_CLAMP);
      tag1_q    <= tag1_d;

      tag2_q    <= tag2_d;

      tag3_q    <= tag2_q;
      lin3_q    <= lin_d;

      tag4_q    <= tag3_q;
      lin4_q    <= lin3_q;
      q4_q      <= pq[2*LIN_W-1:LIN_W];

      tag5_q    <= tag4_q;
      r5_q      <= r_d;

      tag6_q    <= tag5_q;
      addr6_q   <= tag5_q.sample ? r_fix[AW-1:0] : AW'(tag5_q.idx);
    end
  end

  always_comb begin
    req_o.valid    = vld_q[5];
    req_o.sample   = tag6_q.sample;
    req_o.write_ok = tag6_q.write_ok;
    req_o.x        = tag6_q.x;
    req_o.y        = tag6_q.y;
    req_o.wdata    = tag6_q.rgb;
  end

  assign addr_o = addr6_q;

endmodule

/* design/texture_nearest_sampler.sv */
`timescale 1ns / 1ps
// Throughput: one transaction per cycle, write or sample, unless a result is
// held at the output. Each uses the single texel RAM port once, in arrival
// order, except a write to an index beyond the store, which does not use it.
// Reset clears the pipeline valid bits and sets repeat mode and a 256 by 256
// texture; the texel RAM is not cleared and holds nothing defined until written.

module texture_nearest_sampler #(
  parameter int STORE_DEPTH   = tns_pkg::STORE_DEPTH_DEF,
  parameter int FRACTION_BITS = tns_pkg::FRACTION_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tns_stream_if.sink   in_i,
  tns_stream_if.source out_o,
  tns_stream_if.sink   cfg_i
);

  import tns_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  // Configuration registers. The user's writes must come only while idle; the
  // block does not enforce it. The pipeline reads them directly, not a copy.
  tns_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.data.reg_index)
        CFG_WRAP_MODE:  cfg_d.wrap_mode  = wrap_mode_e'(cfg_i.data.wdata[0]);
        CFG_TEX_WIDTH:  cfg_d.tex_width  = cfg_i.data.wdata;
        CFG_TEX_HEIGHT: cfg_d.tex_height = cfg_i.data.wdata;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wrap_mode  <= WRAP_REPEAT;
      cfg_q.tex_width  <= TEX_SIZE_RST;
      cfg_q.tex_height <= TEX_SIZE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_i.ready = 1'b1;

  // The whole pipeline moves as one. It only halts when a finished result
  // sits in the output stage and the consumer is not taking it; in that case
  // the RAM is not enabled, so its registered read data holds the result.
  logic     s7_valid_q;
  logic     adv;
  logic     in_accept;

  assign adv         = !s7_valid_q || out_o.ready;
  assign in_i.ready  = adv;
  assign in_accept   = in_i.valid && in_i.ready;

  // Address pipeline: fold, scale, linearise and reduce modulo the store depth.
  tns_req_t      req;
  logic [AW-1:0] ram_addr;

  tns_addr_gen #(
    .STORE_DEPTH   (STORE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_addr_gen (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .accept_i (in_accept),
    .item_i   (in_i.data),
    .cfg_i    (cfg_q),
    .req_o    (req),
    .addr_o   (ram_addr)
  );

  // Writes and reads share one port at the same pipeline stage, so every
  // sample sees exactly the writes that were accepted before it. Writes to an
  // index beyond the store are dropped.
  logic               ram_en;
  logic               ram_we;
  logic [TEXEL_W-1:0] ram_rdata;

  assign ram_we = !req.sample && req.write_ok;
  assign ram_en = adv && req.valid && (req.sample || req.write_ok);

  tns_ram #(
    .WIDTH (TEXEL_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (req.wdata),
    .rdata_o (ram_rdata)
  );

  // Output stage: the RAM read register carries the texel, these carry the
  // selected column and row alongside it.
  logic [SIZE_W-1:0] s7_x_q, s7_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_valid_q <= 1'b0;
    end else if (adv) begin
      s7_valid_q <= req.valid && req.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_x_q <= req.x;
      s7_y_q <= req.y;
    end
  end

  assign out_o.valid          = s7_valid_q;
  assign out_o.data.red_out   = ram_rdata[3*CH_W-1:2*CH_W];
  assign out_o.data.green_out = ram_rdata[2*CH_W-1:CH_W];
  assign out_o.data.blue_out  = ram_rdata[CH_W-1:0];
  assign out_o.data.texel_x   = s7_x_q[CH_W-1:0];
  assign out_o.data.texel_y   = s7_y_q[CH_W-1:0];

`ifndef SYNTH
  // Every RAM access stays inside the store after the modulo reduction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_en |-> (32'(ram_addr) < 32'(STORE_DEPTH)))
    else $error("texel RAM address beyond store depth");

  // A new result must come from a RAM read issued in the cycle before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s7_valid_q) |-> $past(ram_en && !ram_we))
    else $error("result raised without a texel read");

  // A held result must stall the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s7_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while the output stage is stalled");
`endif

endmodule

/* bench/tns_sampler_checker.sv */
`timescale 1ns / 1ps

module tns_sampler_checker
  import tns_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  cfg_write_t  cfg_data_i,
  output int unsigned pending_o,
  output int unsigned failures_o
);

  localparam int FRAC = FRACTION_BITS_DEF;
  localparam int ONE  = 1 << FRAC;

  typedef logic signed [COORD_W-1:0] coord_t;

  wrap_mode_e        wrap_sel;
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;

  logic [TEXEL_W-1:0] texel_mem [STORE_DEPTH_DEF];
  out_item_t          sample_q [$];
  int unsigned        fault_total = 0;

  assign failures_o = fault_total;

  // Brings a coordinate into the range 0 to 1.0 for the current wrap mode.
  function automatic logic [FRAC:0] fold_coord(input coord_t c);
    logic [FRAC-1:0] low;
    low = c[FRAC-1:0];
    if (wrap_sel == WRAP_CLAMP) begin
      if (c > ONE) return ONE[FRAC:0];
      if (c < 0) return '0;
      return c[FRAC:0];
    end
    // In repeat mode a whole value above one maps to 1.0, not to zero.
    if (c > ONE) return (low == '0) ? ONE[FRAC:0] : {1'b0, low};
    if (c < 0) return {1'b0, low};
    return c[FRAC:0];
  endfunction

  function automatic logic [SIZE_W-1:0] scale_coord(input logic [FRAC:0] f,
                                                    input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0]      span;
    logic [FRAC+SIZE_W:0]   prod;
    span = (size == '0) ? '0 : size - 1'b1;
    prod = f * span;
    return prod[FRAC+SIZE_W-1:FRAC];
  endfunction

  // Store address of the texel that a sample at (u, v) reads, with its column and row.
  function automatic logic [IDX_W-1:0] texel_addr(input coord_t u, input coord_t v,
                                                  output logic [SIZE_W-1:0] col,
                                                  output logic [SIZE_W-1:0] row);
    logic [SIZE_W-1:0] pitch;
    logic [LIN_W+1:0]  lin;
    col   = scale_coord(fold_coord(u), width_reg);
    row   = scale_coord(fold_coord(v), height_reg);
    pitch = (width_reg == '0) ? SIZE_W'(1) : width_reg;
    lin   = row * pitch + col;
    return lin[IDX_W-1:0];
  endfunction

  task automatic check_field(input string name, input logic [CH_W-1:0] want,
                             input logic [CH_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [IDX_W-1:0]   addr;
    logic [SIZE_W-1:0]  col;
    logic [SIZE_W-1:0]  row;
    logic [TEXEL_W-1:0] texel;
    out_item_t          want;
    if (!rst_ni) begin
      wrap_sel   = WRAP_REPEAT;
      width_reg  = TEX_SIZE_RST;
      height_reg = TEX_SIZE_RST;
      sample_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_data_i.reg_index)
          CFG_WRAP_MODE:  wrap_sel   = wrap_mode_e'(cfg_data_i.wdata[0]);
          CFG_TEX_WIDTH:  width_reg  = cfg_data_i.wdata;
          CFG_TEX_HEIGHT: height_reg = cfg_data_i.wdata;
          default: ;
        endcase
      end
      // A result never leaves in the cycle its sample is accepted, so retire before queueing.
      if (out_valid_i && out_ready_i) begin
        if (sample_q.size() == 0) begin
          $error("result with no sample outstanding: x %0d y %0d",
                 out_data_i.texel_x, out_data_i.texel_y);
          fault_total++;
        end else begin
          want = sample_q.pop_front();
          check_field("red_out", want.red_out, out_data_i.red_out);
          check_field("green_out", want.green_out, out_data_i.green_out);
          check_field("blue_out", want.blue_out, out_data_i.blue_out);
          check_field("texel_x", want.texel_x, out_data_i.texel_x);
          check_field("texel_y", want.texel_y, out_data_i.texel_y);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.cmd == CMD_WRITE) begin
          texel_mem[in_data_i.texel_index] = {in_data_i.red_in, in_data_i.green_in,
                                              in_data_i.blue_in};
        end else begin
          addr           = texel_addr(in_data_i.coord_u, in_data_i.coord_v, col, row);
          texel          = texel_mem[addr];
          want.red_out   = texel[3*CH_W-1:2*CH_W];
          want.green_out = texel[2*CH_W-1:CH_W];
          want.blue_out  = texel[CH_W-1:0];
          want.texel_x   = col[CH_W-1:0];
          want.texel_y   = row[CH_W-1:0];
          sample_q.push_back(want);
        end
      end
      pending_o <= sample_q.size();
    end
  end

endmodule

/* bench/texture_nearest_sampler_test.sv */
`timescale 1ns / 1ps

// Stimulus for the nearest-texel sampler. The checker beside the block watches all
// three channels, predicts every sample result and counts mismatches; this module
// only generates traffic, applies idle gaps and back-pressure, and gives the verdict.

module texture_nearest_sampler_test;

  import tns_pkg::*;

  localparam int ONE            = 1 << FRACTION_BITS_DEF;
  localparam int ITEM_TARGET    = 1750;
  localparam int PHASE_ITEMS    = 160;
  // Time for trailing writes to leave the pipeline, with a margin on top.
  localparam int DRAIN_CYCLES   = 12;
  localparam int CHOKE_CYCLES   = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef logic signed [COORD_W-1:0] coord_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  tns_stream_if #(.payload_t(in_item_t))   in_ch ();
  tns_stream_if #(.payload_t(out_item_t))  out_ch ();
  tns_stream_if #(.payload_t(cfg_write_t)) cfg_ch ();

  int unsigned pending_count;
  int unsigned failure_count;

  texture_nearest_sampler uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  tns_sampler_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .in_data_i   (in_ch.data),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_data_i  (out_ch.data),
    .cfg_valid_i (cfg_ch.valid),
    .cfg_ready_i (cfg_ch.ready),
    .cfg_data_i  (cfg_ch.data),
    .pending_o   (pending_count),
    .failures_o  (failure_count)
  );

  // The store holds nothing defined until written, so every entry that a sample
  // will read is written first. Transactions are served in order, so marking an
  // entry when its write is issued is enough.
  bit texel_written [STORE_DEPTH_DEF];

  int unsigned items_sent;
  int          sender_burst;
  bit          sender_quiet;
  // Raised once by the stimulus; the receiver then holds off for a long stretch.
  bit          choke_req;

  // Offers one input transaction after a random gap and waits until it is taken.
  // The sender alternates between stretches with random gaps and stretches with none.
  task automatic push_item(input in_item_t txn);
    int gap;
    if (sender_burst == 0) begin
      sender_burst = $urandom_range(20, 80);
      sender_quiet = ($urandom_range(0, 3) == 0);
    end
    sender_burst--;
    gap = sender_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= txn;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic write_texel(input logic [IDX_W-1:0] index, input logic [CH_W-1:0] red,
                             input logic [CH_W-1:0] green, input logic [CH_W-1:0] blue);
    in_item_t txn;
    txn.cmd         = CMD_WRITE;
    // The coordinates are ignored by a write, but their bits are still exercised.
    txn.coord_u     = coord_t'($urandom());
    txn.coord_v     = coord_t'($urandom());
    txn.texel_index = index;
    txn.red_in      = red;
    txn.green_in    = green;
    txn.blue_in     = blue;
    texel_written[index] = 1'b1;
    push_item(txn);
  endtask

  // Issues a sample, preceded by a write of the addressed texel if it has none yet.
  // The address comes from the checker's own predictor under the current settings.
  task automatic sample_at(input coord_t u, input coord_t v);
    in_item_t           txn;
    logic [IDX_W-1:0]   addr;
    logic [SIZE_W-1:0]  col;
    logic [SIZE_W-1:0]  row;
    addr = chk.texel_addr(u, v, col, row);
    if (!texel_written[addr]) begin
      write_texel(addr, CH_W'($urandom()), CH_W'($urandom()), CH_W'($urandom()));
    end
    txn.cmd         = CMD_SAMPLE;
    txn.coord_u     = u;
    txn.coord_v     = v;
    txn.texel_index = IDX_W'($urandom());
    txn.red_in      = CH_W'($urandom());
    txn.green_in    = CH_W'($urandom());
    txn.blue_in     = CH_W'($urandom());
    push_item(txn);
  endtask

  // Waits until every expected result has arrived and any trailing writes have
  // left the pipeline, so that the block is idle for a register write.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_put(input cfg_reg_e index, input logic [SIZE_W-1:0] value);
    cfg_write_t wr;
    wr.reg_index = index;
    wr.wdata     = value;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= wr;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  // The extra edge at the end lets the checker take the last register write
  // before the predictor is asked for any address.
  task automatic set_config(input wrap_mode_e wrap, input logic [SIZE_W-1:0] width,
                            input logic [SIZE_W-1:0] height);
    cfg_put(CFG_WRAP_MODE, {{(SIZE_W-1){1'b0}}, wrap});
    cfg_put(CFG_TEX_WIDTH, width);
    cfg_put(CFG_TEX_HEIGHT, height);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Coordinates are a mix of in-range values, values on and around the edges of
  // the unit range, whole values of either sign and fully random 24-bit patterns.
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom_range(0, ONE));
      1: begin
        case ($urandom_range(0, 8))
          0: return coord_t'(0);
          1: return coord_t'(ONE);
          2: return coord_t'(ONE - 1);
          3: return coord_t'(ONE + 1);
          4: return coord_t'(-1);
          5: return coord_t'(2 * ONE);
          6: return coord_t'(-ONE);
          7: return {1'b0, {(COORD_W-1){1'b1}}};
          default: return {1'b1, {(COORD_W-1){1'b0}}};
        endcase
      end
      2: return {8'($urandom()), 16'h0000};
      default: return coord_t'($urandom());
    endcase
  endfunction

  // Receiver: random stalls before each result, quiet stretches without any, and
  // one long hold-off while the sender keeps offering, so that the block backs up.
  initial begin
    int stall;
    int burst_left;
    bit quiet;
    bit choked;
    burst_left = 0;
    quiet      = 1'b0;
    choked     = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(20, 80);
        quiet      = ($urandom_range(0, 3) == 0);
      end
      burst_left--;
      stall = quiet ? 0 : $urandom_range(0, 13);
      if (choke_req && !choked) begin
        choked = 1'b1;
        stall  = CHOKE_CYCLES;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // Ends the run if no transaction is accepted on any channel for too long.
  int unsigned idle_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[texture_nearest_sampler] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int                phase;
    int                area;
    wrap_mode_e        wrap;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    items_sent   = 0;
    sender_burst = 0;
    sender_quiet = 1'b0;
    choke_req    = 1'b0;
    rst_ni       = 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Repeat mode on a full 256 by 256 texture first: the corner
    // texels, whole values above one, negative values and the coordinate extremes.
    set_config(WRAP_REPEAT, SIZE_W'(256), SIZE_W'(256));
    write_texel('0, '0, '0, '0);
    write_texel('1, '1, '1, '1);
    sample_at(coord_t'(0), coord_t'(0));
    sample_at(coord_t'(ONE), coord_t'(ONE));
    sample_at(coord_t'(2 * ONE), coord_t'(3 * ONE + ONE / 4));
    sample_at(coord_t'(-ONE), coord_t'(-ONE / 4));
    sample_at({1'b0, {(COORD_W-1){1'b1}}}, {1'b1, {(COORD_W-1){1'b0}}});
    settle();

    // Clamp to edge: saturation at both ends and a value just under one.
    set_config(WRAP_CLAMP, SIZE_W'(256), SIZE_W'(256));
    sample_at({1'b0, {(COORD_W-1){1'b1}}}, {1'b1, {(COORD_W-1){1'b0}}});
    sample_at(coord_t'(-ONE / 4), coord_t'(ONE + ONE / 2));
    sample_at(coord_t'(ONE / 2), coord_t'(ONE - 1));
    settle();

    // A width register of zero behaves as a width of one.
    set_config(WRAP_CLAMP, SIZE_W'(0), SIZE_W'(3));
    sample_at(coord_t'(ONE * 7 / 10), coord_t'(ONE));
    settle();

    // Widths beyond 256: the reported column keeps only its low eight bits.
    set_config(WRAP_REPEAT, SIZE_W'(300), SIZE_W'(2));
    sample_at(coord_t'(ONE), coord_t'(ONE));
    sample_at(coord_t'(ONE / 2), coord_t'(0));
    settle();

    // The largest texture overruns the store, so the address wraps round.
    set_config(WRAP_CLAMP, '1, '1);
    sample_at(coord_t'(ONE), coord_t'(ONE));
    sample_at(coord_t'(ONE / 3), coord_t'(ONE * 2 / 3));
    settle();

    // Random part: one setting per phase, mostly small textures, now and then the
    // full size, a zero register or one beyond 256.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wrap = wrap_mode_e'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0: begin
          width  = SIZE_W'(256);
          height = SIZE_W'(256);
        end
        1: begin
          width  = SIZE_W'(1);
          height = SIZE_W'(1);
        end
        2: begin
          width  = SIZE_W'($urandom_range(257, 511));
          height = SIZE_W'($urandom_range(1, 4));
        end
        3: begin
          width  = SIZE_W'($urandom_range(1, 4));
          height = SIZE_W'($urandom_range(257, 511));
        end
        4: begin
          width  = SIZE_W'(0);
          height = SIZE_W'($urandom_range(0, 16));
        end
        default: begin
          width  = SIZE_W'($urandom_range(1, 32));
          height = SIZE_W'($urandom_range(1, 32));
        end
      endcase
      set_config(wrap, width, height);
      area = ((width == '0) ? 1 : int'(width)) * ((height == '0) ? 1 : int'(height));
      if (area > STORE_DEPTH_DEF) area = STORE_DEPTH_DEF;
      // The receiver's long hold-off starts during the second phase.
      if (phase == 1) choke_req = 1'b1;
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 35) begin
          // Half the writes land inside the current texture, half anywhere.
          write_texel(($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, area - 1))
                                                  : IDX_W'($urandom()),
                      CH_W'($urandom()), CH_W'($urandom()), CH_W'($urandom()));
        end else begin
          sample_at(rand_coord(), rand_coord());
        end
      end
      settle();
      phase++;
    end

    if (failure_count == 0) begin
      $display("[texture_nearest_sampler] OK");
    end else begin
      $display("[texture_nearest_sampler] ERROR");
    end
    $finish;
  end

endmodule
